### sv/sqed_pkg.sv
// Package for the squared Euclidean distance block with early termination.
// Holds the shared widths, constants and the stage control struct.
// No dependencies; compile this file first.
package sqed_pkg;

  localparam int LANES        = 4;
  localparam int ELEM_FIELD_W = 16;
  localparam int ELEM_BITS    = 16;
  localparam int SUM_W        = 40;
  localparam int SQ_W         = 2 * (ELEM_BITS + 1);
  localparam int GRP_W        = SQ_W + $clog2(LANES);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Control that travels with one group between pipeline stages.
  typedef struct packed {
    logic valid;
    logic last;
  } stage_t;

endpackage

### sv/sqed_if.sv
// Channel interfaces of the squared distance block: input groups, results
// and the threshold write channel. Depends on sqed_pkg.
interface sqed_in_if import sqed_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [ELEM_FIELD_W-1:0] first_a0;
  logic signed [ELEM_FIELD_W-1:0] first_a1;
  logic signed [ELEM_FIELD_W-1:0] first_a2;
  logic signed [ELEM_FIELD_W-1:0] first_a3;
  logic signed [ELEM_FIELD_W-1:0] second_b0;
  logic signed [ELEM_FIELD_W-1:0] second_b1;
  logic signed [ELEM_FIELD_W-1:0] second_b2;
  logic signed [ELEM_FIELD_W-1:0] second_b3;
  logic                           vector_end;

  modport source (
    output valid, first_a0, first_a1, first_a2, first_a3,
           second_b0, second_b1, second_b2, second_b3, vector_end,
    input  ready
  );
  modport sink (
    input  valid, first_a0, first_a1, first_a2, first_a3,
           second_b0, second_b1, second_b2, second_b3, vector_end,
    output ready
  );
endinterface

interface sqed_out_if import sqed_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] distance_sum;
  logic             over_threshold;

  modport source (output valid, distance_sum, over_threshold, input ready);
  modport sink (input valid, distance_sum, over_threshold, output ready);
endinterface

interface sqed_cfg_if import sqed_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] distance_threshold;

  modport source (output valid, distance_threshold, input ready);
  modport sink (input valid, distance_threshold, output ready);
endinterface

### sv/sqed_lane.sv
// One lane: difference of two sign-extended elements and its registered
// square. Depends on sqed_pkg.
module sqed_lane import sqed_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [ELEM_FIELD_W-1:0] a_i,
  input  logic [ELEM_FIELD_W-1:0] b_i,
  output logic [SQ_W-1:0]         sq_o
);

  logic [ELEM_BITS-1:0] a_low;
  logic [ELEM_BITS-1:0] b_low;
  logic [ELEM_BITS:0]   diff;
  logic [ELEM_BITS:0]   mag;
  logic [SQ_W-1:0]      sq_d;
  logic [SQ_W-1:0]      sq_q;

  assign a_low = a_i[ELEM_BITS-1:0];
  assign b_low = b_i[ELEM_BITS-1:0];

  // Only the low element bits count; they are sign-extended by one bit so
  // the difference cannot overflow.
  assign diff = {a_low[ELEM_BITS-1], a_low} - {b_low[ELEM_BITS-1], b_low};
  assign mag  = diff[ELEM_BITS] ? (~diff + 1'b1) : diff;
  assign sq_d = SQ_W'(mag) * SQ_W'(mag);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

### sv/sqed_merge.sv
// Merging stage: adds the squares of all lanes into one registered group
// sum. Depends on sqed_pkg.
module sqed_merge import sqed_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SQ_W-1:0]  sq_i [LANES],
  output logic [GRP_W-1:0] grp_o
);

  logic [GRP_W-1:0] grp_d;
  logic [GRP_W-1:0] grp_q;

  always_comb begin
    grp_d = '0;
    for (int k = 0; k < LANES; k++) begin
      grp_d = grp_d + GRP_W'(sq_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q <= grp_d;
    end
  end

  assign grp_o = grp_q;

endmodule

### sv/sqed_accum.sv
// Running sum with saturation, threshold check, abort flag and the result
// output register. Depends on sqed_pkg.
module sqed_accum import sqed_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stage_t           stage_i,
  input  logic [GRP_W-1:0] grp_i,
  input  logic [SUM_W-1:0] threshold_i,
  input  logic             out_ready_i,
  output logic             take_o,
  output logic             out_valid_o,
  output logic [SUM_W-1:0] out_sum_o,
  output logic             out_over_o
);

  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sum_d;
  logic             aborted_q;
  logic             aborted_d;
  logic             out_valid_q;
  logic [SUM_W-1:0] out_sum_q;
  logic             out_over_q;
  logic [SUM_W:0]   ext_sum;
  logic [SUM_W-1:0] sat_sum;
  logic             out_free;
  logic             take;

  assign ext_sum = {1'b0, sum_q} + (SUM_W + 1)'(grp_i);
  assign sat_sum = ext_sum[SUM_W] ? SUM_MAX : ext_sum[SUM_W-1:0];

  // Once aborted, groups add nothing and are not checked again.
  assign sum_d     = aborted_q ? sum_q : sat_sum;
  assign aborted_d = aborted_q | (sat_sum > threshold_i);

  // A group that does not end a vector never needs the output register.
  assign out_free = !out_valid_q || out_ready_i;
  assign take     = stage_i.valid && (!stage_i.last || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      aborted_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        if (stage_i.last) begin
          sum_q     <= '0;
          aborted_q <= 1'b0;
        end else begin
          sum_q     <= sum_d;
          aborted_q <= aborted_d;
        end
      end
      if (take && stage_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && stage_i.last) begin
      out_sum_q  <= aborted_d ? SUM_MAX : sum_d;
      out_over_q <= aborted_d;
    end
  end

  assign take_o      = take;
  assign out_valid_o = out_valid_q;
  assign out_sum_o   = out_sum_q;
  assign out_over_o  = out_over_q;

endmodule

### sv/sq_euclid_dist_early_exit.sv
// Top level of the squared Euclidean distance block with early termination.
// Instantiates sqed_lane, sqed_merge and sqed_accum; uses sqed_pkg and sqed_if.
//
// Each input transaction carries one group of four element pairs of two
// descriptors, as signed 16-bit fixed point. Four lanes form the squared
// differences in parallel, a merging stage adds them, and an accumulator
// adds the group into the running sum of the current vector pair, saturating
// at all ones. When the running sum goes strictly above distance_threshold
// the vector is aborted and its remaining groups are ignored. The group with
// vector_end set produces exactly one result transaction: the sum with
// over_threshold low, or all ones with over_threshold high if the vector was
// aborted. The block accepts one group every clock cycle unless the input
// stalls; a last group's result is registered by the square, the group add
// and then the accumulation into the output register. The accumulator loop (a
// 40-bit add, saturate and compare) sets the issue rate. Groups keep flowing
// while a result waits to be taken; the input stalls only when the pipeline
// is full and its oldest group ends a vector whose result cannot be stored.
// The threshold resets to all ones, is always ready to be written, and
// should be written only while no vector is in flight.
module sq_euclid_dist_early_exit import sqed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sqed_in_if.sink     in_i,
  sqed_cfg_if.sink    cfg_i,
  sqed_out_if.source  out_o
);

  logic [SUM_W-1:0]        threshold_q;
  logic [ELEM_FIELD_W-1:0] elem_a [LANES];
  logic [ELEM_FIELD_W-1:0] elem_b [LANES];
  logic [SQ_W-1:0]         lane_sq [LANES];
  logic [GRP_W-1:0]        grp_sum;
  stage_t                  s1_q;
  stage_t                  s2_q;
  logic                    s1_en;
  logic                    s2_en;
  logic                    acc_take;
  logic                    in_take;

  // Threshold register; the write channel never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= SUM_MAX;
    end else if (cfg_i.valid) begin
      threshold_q <= cfg_i.distance_threshold;
    end
  end

  // Stage enables: each stage moves when it is empty or its content moves on.
  assign s2_en      = !s2_q.valid || acc_take;
  assign s1_en      = !s1_q.valid || s2_en;
  assign in_i.ready = s1_en;
  assign in_take    = in_i.valid && s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      if (s1_en) begin
        s1_q.valid <= in_take;
        s1_q.last  <= in_i.vector_end;
      end
      if (s2_en) begin
        s2_q <= s1_q;
      end
    end
  end

  assign elem_a[0] = in_i.first_a0;
  assign elem_a[1] = in_i.first_a1;
  assign elem_a[2] = in_i.first_a2;
  assign elem_a[3] = in_i.first_a3;
  assign elem_b[0] = in_i.second_b0;
  assign elem_b[1] = in_i.second_b1;
  assign elem_b[2] = in_i.second_b2;
  assign elem_b[3] = in_i.second_b3;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    sqed_lane u_lane (
      .clk_i (clk_i),
      .en_i  (s1_en),
      .a_i   (elem_a[k]),
      .b_i   (elem_b[k]),
      .sq_o  (lane_sq[k])
    );
  end

  sqed_merge u_merge (
    .clk_i (clk_i),
    .en_i  (s2_en),
    .sq_i  (lane_sq),
    .grp_o (grp_sum)
  );

  sqed_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (s2_q),
    .grp_i       (grp_sum),
    .threshold_i (threshold_q),
    .out_ready_i (out_o.ready),
    .take_o      (acc_take),
    .out_valid_o (out_o.valid),
    .out_sum_o   (out_o.distance_sum),
    .out_over_o  (out_o.over_threshold)
  );

  // An exceeded result always reports the saturated sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.over_threshold) |-> (out_o.distance_sum == SUM_MAX))
    else $error("exceeded result without all-ones sum");

  // The input stalls only when every stage is full behind a blocked result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_q.valid && s2_q.valid && s2_q.last && out_o.valid &&
                     !out_o.ready))
    else $error("input stalled while the pipeline could move");

  // A result appears only after a vector-ending group entered the accumulator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(acc_take && s2_q.last))
    else $error("result without a vector-ending group");

endmodule

### dv/sq_euclid_dist_early_exit_test.sv
`timescale 1ns / 100ps
// Testbench for sq_euclid_dist_early_exit: directed and random groups, each result checked
// against a predicted squared distance. Needs sqed_pkg, the sqed_if interfaces and the RTL.
module sq_euclid_dist_early_exit_test;
  import sqed_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;
  localparam int IdlePercent = 27;

  // One input transaction: four element pairs and the end-of-vector mark.
  typedef struct packed {
    logic [LANES-1:0][ELEM_FIELD_W-1:0] a;
    logic [LANES-1:0][ELEM_FIELD_W-1:0] b;
    logic                               last;
  } group_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             over;
  } dist_t;

  logic clk_i;
  logic rst_ni;

  sqed_in_if  in_ch();
  sqed_cfg_if cfg_ch();
  sqed_out_if out_ch();

  sq_euclid_dist_early_exit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  // Predicted state of the block and the distances still owed by it.
  logic [SUM_W-1:0] model_threshold;
  logic [SUM_W-1:0] model_sum;
  logic             model_aborted;
  dist_t            pending_dist_q[$];

  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("sq_euclid_dist_early_exit verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("%0t: MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Sum of the four squared lane differences of one group. Elements are
  // taken as signed values of ELEM_BITS bits.
  function automatic longint unsigned group_energy(input group_t g);
    longint          d;
    longint unsigned acc;
    int              k;
    acc = 0;
    for (k = 0; k < LANES; k++) begin
      d = longint'($signed(g.a[k][ELEM_BITS-1:0])) - longint'($signed(g.b[k][ELEM_BITS-1:0]));
      acc += longint'(d * d);
    end
    return acc;
  endfunction

  // Advances the predicted accumulator by one accepted group. Once a vector
  // has gone over the threshold its later groups add nothing; the marked
  // last group always owes one result.
  task automatic accumulate_group(input group_t g);
    longint unsigned total;
    dist_t           res;
    if (!model_aborted) begin
      total = 64'(model_sum) + group_energy(g);
      if (total > 64'(SUM_MAX)) total = 64'(SUM_MAX);
      model_sum = total[SUM_W-1:0];
      if (model_sum > model_threshold) model_aborted = 1'b1;
    end
    if (g.last) begin
      if (model_aborted) begin
        res.sum  = SUM_MAX;
        res.over = 1'b1;
      end else begin
        res.sum  = model_sum;
        res.over = 1'b0;
      end
      pending_dist_q.push_back(res);
      model_sum     = '0;
      model_aborted = 1'b0;
    end
  endtask

  // Result side: ready drops at random while idling is on.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= !idle_on || ($urandom_range(99) >= IdlePercent);
    end
  end

  always @(posedge clk_i) begin
    dist_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_dist_q.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(out_ch.distance_sum), 64'(0));
      end else begin
        want = pending_dist_q.pop_front();
        if (out_ch.distance_sum !== want.sum) begin
          report_mismatch("distance_sum", 64'(out_ch.distance_sum), 64'(want.sum));
        end
        if (out_ch.over_threshold !== want.over) begin
          report_mismatch("over_threshold", 64'(out_ch.over_threshold), 64'(want.over));
        end
      end
    end
  end

  // Presents one group and returns at the edge where it is accepted. Valid
  // stays high afterwards so back-to-back groups need only one assignment
  // per falling edge.
  task automatic send_group(input group_t g);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < IdlePercent) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.first_a0   <= g.a[0];
    in_ch.first_a1   <= g.a[1];
    in_ch.first_a2   <= g.a[2];
    in_ch.first_a3   <= g.a[3];
    in_ch.second_b0  <= g.b[0];
    in_ch.second_b1  <= g.b[1];
    in_ch.second_b2  <= g.b[2];
    in_ch.second_b3  <= g.b[3];
    in_ch.vector_end <= g.last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    accumulate_group(g);
  endtask

  // Stops the input and waits until every owed result has arrived, then lets
  // the pipeline drain so that nothing is left inside it.
  task automatic quiesce();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_dist_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [SUM_W-1:0] thr);
    quiesce();
    @(negedge clk_i);
    cfg_ch.valid              <= 1'b1;
    cfg_ch.distance_threshold <= thr;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    model_threshold = thr;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic group_t lane_group(input logic [ELEM_FIELD_W-1:0] a0, a1, a2, a3,
                                        input logic [ELEM_FIELD_W-1:0] b0, b1, b2, b3,
                                        input bit last);
    group_t g;
    g.a    = {a3, a2, a1, a0};
    g.b    = {b3, b2, b1, b0};
    g.last = last;
    return g;
  endfunction

  function automatic group_t pair_group(input logic [ELEM_FIELD_W-1:0] a, b, input bit last);
    return lane_group(a, a, a, a, b, b, b, b, last);
  endfunction

  // Random group: mostly full-range elements, with small values, extremes
  // and equal pairs mixed in so that zero sums and near-threshold sums occur.
  function automatic group_t random_group(input bit last);
    group_t g;
    int     k;
    int     mode;
    mode = $urandom_range(9);
    for (k = 0; k < LANES; k++) begin
      if (mode < 6) begin
        g.a[k] = ELEM_FIELD_W'($urandom);
        g.b[k] = ELEM_FIELD_W'($urandom);
      end else if (mode < 8) begin
        g.a[k] = ELEM_FIELD_W'($urandom_range(16)) - ELEM_FIELD_W'(8);
        g.b[k] = ELEM_FIELD_W'($urandom_range(16)) - ELEM_FIELD_W'(8);
      end else if (mode == 8) begin
        case ($urandom_range(3))
          0: g.a[k] = 16'h8000;
          1: g.a[k] = 16'h7fff;
          2: g.a[k] = 16'h0000;
          default: g.a[k] = 16'hffff;
        endcase
        g.b[k] = $urandom_range(1) ? ~g.a[k] : 16'h8000;
      end else begin
        g.a[k] = ELEM_FIELD_W'($urandom);
        g.b[k] = g.a[k];
      end
    end
    g.last = last;
    return g;
  endfunction

  // Single-group and short vectors at the element extremes, with the reset
  // threshold of all ones so that nothing aborts.
  task automatic test_extremes();
    send_group(pair_group(16'h0000, 16'h0000, 1'b1));
    send_group(pair_group(16'h7fff, 16'h8000, 1'b1));
    send_group(pair_group(16'h8000, 16'h7fff, 1'b1));
    send_group(pair_group(16'h8000, 16'h8000, 1'b1));
    send_group(lane_group(16'h0001, 16'hffff, 16'h0064, 16'h8000,
                          16'h0000, 16'h0001, 16'hff9c, 16'h0000, 1'b1));
    send_group(pair_group(16'h1234, 16'hedcb, 1'b0));
    send_group(pair_group(16'h5555, 16'haaaa, 1'b0));
    send_group(pair_group(16'hffff, 16'h0001, 1'b1));
  endtask

  // Exact threshold rule: a sum equal to the threshold passes, one above
  // aborts; groups after an abort are ignored and the abort can happen on
  // the last group itself.
  task automatic test_threshold();
    set_threshold('0);
    send_group(pair_group(16'h0000, 16'h0000, 1'b1));
    send_group(lane_group(16'h0001, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_group(lane_group(16'h0001, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_group(pair_group(16'h7fff, 16'h8000, 1'b0));
    send_group(pair_group(16'h0000, 16'h0000, 1'b1));
    send_group(pair_group(16'h0000, 16'h0000, 1'b0));
    send_group(lane_group(0, 0, 0, 16'hffff, 0, 0, 0, 0, 1'b1));
    set_threshold(40'd100);
    send_group(lane_group(16'd10, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_group(lane_group(16'd10, 16'd1, 0, 0, 0, 0, 0, 0, 1'b1));
    send_group(lane_group(16'd5, 16'd5, 0, 0, 0, 0, 0, 0, 1'b0));
    send_group(lane_group(16'd5, 16'd5, 0, 0, 0, 0, 0, 0, 1'b1));
    send_group(lane_group(16'd5, 16'd5, 0, 0, 0, 0, 0, 0, 1'b0));
    send_group(lane_group(16'd5, 16'd5, 0, 0, 0, 0, 0, 0, 1'b0));
    send_group(lane_group(16'd5, 16'd5, 0, 0, 0, 0, 0, 0, 1'b1));
    send_group(lane_group(16'd3, 0, 0, 0, 0, 0, 0, 0, 1'b1));
  endtask

  // Vectors longer than 64 full-scale groups: the sum saturates at all ones,
  // which is not above an all-ones threshold but is above one less.
  task automatic test_saturation();
    int k;
    set_threshold(SUM_MAX);
    for (k = 0; k < 70; k++) send_group(pair_group(16'h7fff, 16'h8000, k == 69));
    set_threshold(SUM_MAX - 1);
    for (k = 0; k < 70; k++) send_group(pair_group(16'h8000, 16'h7fff, k == 69));
  endtask

  // Random vectors, mostly short, now and then longer than 64 groups.
  task automatic test_random(input int n_items, input logic [SUM_W-1:0] thr, input bit idle);
    int sent;
    int len;
    int k;
    set_threshold(thr);
    idle_on = idle;
    sent    = 0;
    while (sent < n_items) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(80, 9) : $urandom_range(8, 1);
      for (k = 0; k < len; k++) send_group(random_group(k == len - 1));
      sent += len;
    end
    quiesce();
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni                    = 1'b0;
    in_ch.valid               = 1'b0;
    in_ch.first_a0            = '0;
    in_ch.first_a1            = '0;
    in_ch.first_a2            = '0;
    in_ch.first_a3            = '0;
    in_ch.second_b0           = '0;
    in_ch.second_b1           = '0;
    in_ch.second_b2           = '0;
    in_ch.second_b3           = '0;
    in_ch.vector_end          = 1'b0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.distance_threshold = '0;
    model_threshold           = SUM_MAX;
    model_sum                 = '0;
    model_aborted             = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_threshold();
    test_saturation();
    // Thresholds range from full scale down to at most 5000; the middle
    // phase runs without any idling on either side.
    test_random(215, SUM_MAX, 1'b1);
    test_random(215, (SUM_W'(1) << 33) | SUM_W'($urandom_range(65535)), 1'b1);
    test_random(215, SUM_W'($urandom) << $urandom_range(4), 1'b0);
    test_random(215, SUM_W'($urandom_range(5000)), 1'b1);
    test_random(215, {8'($urandom), 32'($urandom)}, 1'b1);
    quiesce();

    if (errors == 0) begin
      $display("sq_euclid_dist_early_exit verification clean");
    end else begin
      $display("sq_euclid_dist_early_exit verification failed");
    end
    $finish;
  end

endmodule

### files.f
sv/sqed_pkg.sv
sv/sqed_if.sv
sv/sqed_lane.sv
sv/sqed_merge.sv
sv/sqed_accum.sv
sv/sq_euclid_dist_early_exit.sv
dv/sq_euclid_dist_early_exit_test.sv
